// ===== sv/ettq_pkg.sv =====
// Shared types and constants for the emulated-time timeout queue.
package ettq_pkg;

  localparam int unsigned NumSlots = 16;
  localparam int unsigned SlotW    = $clog2(NumSlots);
  localparam int unsigned TimeW    = 48;
  localparam int unsigned DeltaW   = 32;
  localparam int unsigned OrderW   = 32;
  localparam int unsigned MaxRes   = 16;
  localparam int unsigned CntW     = $clog2(MaxRes + 1);

  typedef enum logic [1:0] {
    REQ_START   = 2'd0,
    REQ_STEP    = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_REL_ALL = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    EV_STARTED  = 2'd0,
    EV_RELEASED = 2'd1,
    EV_QUERY    = 2'd2,
    EV_NONE     = 2'd3
  } ev_e;

  // Candidate that walks down the row of slot cells.
  typedef struct packed {
    logic              valid;
    logic [SlotW-1:0]  id;
    logic [TimeW-1:0]  deadline;
    logic [TimeW-1:0]  start;
    logic [OrderW-1:0] order;
  } cand_t;

  typedef struct packed {
    logic             query;
    logic             only_expired;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] now;
  } scan_ctrl_t;

  typedef struct packed {
    logic              en;
    logic [SlotW-1:0]  slot;
    logic [TimeW-1:0]  start;
    logic [TimeW-1:0]  deadline;
    logic [OrderW-1:0] order;
  } slot_wr_t;

  typedef struct packed {
    logic             en;
    logic             all;
    logic [SlotW-1:0] slot;
  } slot_clr_t;

endpackage

// ===== sv/emulated_time_timeout_queue.sv =====
// Top level of the emulated-time timeout queue: control and the row of slot cells.
//
// Usage: drive a request on req_type_i/slot_i/duration_ns_i/delta_ns_i and
// raise start; the beat is taken at a clock edge where start is high and
// busy is low. Results come out one beat at a time, each marked by a
// one-cycle res_strobe_o; last_o flags the final beat of a request.
// Timing: a start request answers in the next cycle and leaves busy low.
// Query, step and release-all walk a candidate through the 16 slot cells,
// one cell per cycle, then evaluate it in S_EVAL. Step and release-all
// release one slot per pass and end with a pass that finds nothing more
// (a burst of 16 releases ends without that pass).
// Reset clears the clock, the start counter and all slot times and waiting
// bits. Results cannot be stalled: the receiver takes every beat.
module emulated_time_timeout_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [3:0]  slot_i,
  input  logic [47:0] duration_ns_i,
  input  logic [31:0] delta_ns_i,
  output logic        res_strobe_o,
  output logic [1:0]  event_res_o,
  output logic [3:0]  out_slot_o,
  output logic        reached_o,
  output logic [47:0] elapsed_o,
  output logic        last_o
);
  import ettq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_EVAL  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  state_e            state_q, state_d;
  req_e              req_q, req_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [TimeW-1:0]  now_q, now_d;
  logic [OrderW-1:0] ctr_q, ctr_d;
  logic [SlotW-1:0]  scan_q, scan_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              pend_valid_q, pend_valid_d;
  logic [SlotW-1:0]  pend_slot_q, pend_slot_d;
  logic [TimeW-1:0]  pend_el_q, pend_el_d;

  logic              res_strobe_q, res_strobe_d;
  ev_e               res_ev_q, res_ev_d;
  logic [SlotW-1:0]  res_slot_q, res_slot_d;
  logic              res_reached_q, res_reached_d;
  logic [TimeW-1:0]  res_el_q, res_el_d;
  logic              res_last_q, res_last_d;

  scan_ctrl_t        ctrl;
  slot_wr_t          wr;
  slot_clr_t         clr;
  cand_t             cand_in  [NumSlots];
  cand_t             cand_out [NumSlots];
  logic [NumSlots-1:0] waiting;
  cand_t             fin;
  logic              accept;
  logic [TimeW-1:0]  fin_el;

  assign accept = start && (state_q == S_IDLE);
  assign fin    = cand_out[NumSlots-1];
  assign fin_el = now_q - fin.start;

  assign ctrl.query        = (req_q == REQ_QUERY);
  assign ctrl.only_expired = (req_q == REQ_STEP);
  assign ctrl.slot         = slot_q;
  assign ctrl.now          = now_q;

  for (genvar k = 0; k < NumSlots; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cand_in[k] = '0;
    end else begin : g_link
      assign cand_in[k] = cand_out[k-1];
    end
    ettq_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .idx_i     (SlotW'(k)),
      .ctrl_i    (ctrl),
      .wr_i      (wr),
      .clr_i     (clr),
      .cand_i    (cand_in[k]),
      .cand_o    (cand_out[k]),
      .waiting_o (waiting[k])
    );
  end

  always_comb begin
    state_d       = state_q;
    req_d         = req_q;
    slot_d        = slot_q;
    now_d         = now_q;
    ctr_d         = ctr_q;
    scan_d        = scan_q;
    cnt_d         = cnt_q;
    pend_valid_d  = pend_valid_q;
    pend_slot_d   = pend_slot_q;
    pend_el_d     = pend_el_q;
    res_strobe_d  = 1'b0;
    res_ev_d      = res_ev_q;
    res_slot_d    = res_slot_q;
    res_reached_d = res_reached_q;
    res_el_d      = res_el_q;
    res_last_d    = res_last_q;
    wr            = '0;
    clr           = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          req_d        = req_e'(req_type_i);
          slot_d       = slot_i[SlotW-1:0];
          scan_d       = '0;
          cnt_d        = '0;
          pend_valid_d = 1'b0;
          unique case (req_e'(req_type_i))
            REQ_START: begin
              wr.en         = 1'b1;
              wr.slot       = slot_i[SlotW-1:0];
              wr.start      = now_q;
              wr.deadline   = now_q + duration_ns_i;
              wr.order      = ctr_q;
              ctr_d         = ctr_q + 1'b1;
              res_strobe_d  = 1'b1;
              res_ev_d      = EV_STARTED;
              res_slot_d    = slot_i[SlotW-1:0];
              res_reached_d = 1'b0;
              res_el_d      = '0;
              res_last_d    = 1'b1;
            end
            REQ_STEP: begin
              now_d   = now_q + TimeW'(delta_ns_i);
              state_d = S_SCAN;
            end
            default: begin
              state_d = S_SCAN;
            end
          endcase
        end
      end
      S_SCAN: begin
        scan_d = scan_q + 1'b1;
        if (scan_q == SlotW'(NumSlots - 1)) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        scan_d = '0;
        if (req_q == REQ_QUERY) begin
          res_strobe_d  = 1'b1;
          res_ev_d      = EV_QUERY;
          res_slot_d    = fin.id;
          res_reached_d = (now_q >= fin.deadline);
          res_el_d      = fin_el;
          res_last_d    = 1'b1;
          state_d       = S_IDLE;
        end else if (fin.valid) begin
          clr.en   = 1'b1;
          clr.slot = fin.id;
          // hand out the previous release; this one waits to learn if it is last
          if (pend_valid_q) begin
            res_strobe_d  = 1'b1;
            res_ev_d      = EV_RELEASED;
            res_slot_d    = pend_slot_q;
            res_reached_d = 1'b1;
            res_el_d      = pend_el_q;
            res_last_d    = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_slot_d  = fin.id;
          pend_el_d    = fin_el;
          cnt_d        = cnt_q + 1'b1;
          if (cnt_q == CntW'(MaxRes - 1)) begin
            state_d = S_FLUSH;
          end else begin
            state_d = S_SCAN;
          end
        end else begin
          res_strobe_d  = 1'b1;
          res_last_d    = 1'b1;
          if (pend_valid_q) begin
            res_ev_d      = EV_RELEASED;
            res_slot_d    = pend_slot_q;
            res_reached_d = 1'b1;
            res_el_d      = pend_el_q;
          end else begin
            res_ev_d      = EV_NONE;
            res_slot_d    = '0;
            res_reached_d = 1'b0;
            res_el_d      = '0;
          end
          clr.all      = (req_q == REQ_REL_ALL);
          pend_valid_d = 1'b0;
          cnt_d        = '0;
          state_d      = S_IDLE;
        end
      end
      S_FLUSH: begin
        res_strobe_d  = 1'b1;
        res_ev_d      = EV_RELEASED;
        res_slot_d    = pend_slot_q;
        res_reached_d = 1'b1;
        res_el_d      = pend_el_q;
        res_last_d    = 1'b1;
        clr.all       = (req_q == REQ_REL_ALL);
        pend_valid_d  = 1'b0;
        cnt_d         = '0;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      req_q        <= REQ_START;
      slot_q       <= '0;
      now_q        <= '0;
      ctr_q        <= '0;
      scan_q       <= '0;
      cnt_q        <= '0;
      pend_valid_q <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      req_q        <= req_d;
      slot_q       <= slot_d;
      now_q        <= now_d;
      ctr_q        <= ctr_d;
      scan_q       <= scan_d;
      cnt_q        <= cnt_d;
      pend_valid_q <= pend_valid_d;
      res_strobe_q <= res_strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_slot_q   <= pend_slot_d;
    pend_el_q     <= pend_el_d;
    res_ev_q      <= res_ev_d;
    res_slot_q    <= res_slot_d;
    res_reached_q <= res_reached_d;
    res_el_q      <= res_el_d;
    res_last_q    <= res_last_d;
  end

  assign busy         = (state_q != S_IDLE);
  assign res_strobe_o = res_strobe_q;
  assign event_res_o  = res_ev_q;
  assign out_slot_o   = res_slot_q;
  assign reached_o    = res_reached_q;
  assign elapsed_o    = res_el_q;
  assign last_o       = res_last_q;

`ifndef SYNTHESIS
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> !pend_valid_q)
    else $error("pending release held while idle");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxRes))
    else $error("release count beyond burst limit");

  a_release_reached: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && (event_res_o == EV_RELEASED)) |-> reached_o)
    else $error("released slot reported as not reached");

  a_release_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_EVAL) && (req_q != REQ_QUERY) && fin.valid) |=>
      !waiting[$past(fin.id)])
    else $error("released slot still waiting");
`endif

endmodule

// ===== sv/ettq_cell.sv =====
// One timeout slot: its stored times and one stage of the candidate chain.
module ettq_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [ettq_pkg::SlotW-1:0] idx_i,
  input  ettq_pkg::scan_ctrl_t       ctrl_i,
  input  ettq_pkg::slot_wr_t         wr_i,
  input  ettq_pkg::slot_clr_t        clr_i,
  input  ettq_pkg::cand_t            cand_i,
  output ettq_pkg::cand_t            cand_o,
  output logic                       waiting_o
);
  import ettq_pkg::*;

  logic [TimeW-1:0]  start_q;
  logic [TimeW-1:0]  deadline_q;
  logic [OrderW-1:0] order_q;
  logic              waiting_q;
  cand_t             cand_q, cand_d;
  logic              eligible, take;

  always_comb begin
    if (ctrl_i.query) begin
      eligible = (ctrl_i.slot == idx_i);
    end else begin
      eligible = waiting_q && (!ctrl_i.only_expired || (deadline_q <= ctrl_i.now));
    end
    // strict compare keeps the lower slot on a full tie
    take = eligible && (ctrl_i.query || !cand_i.valid ||
                        (deadline_q < cand_i.deadline) ||
                        ((deadline_q == cand_i.deadline) && (order_q < cand_i.order)));
    if (take) begin
      cand_d.valid    = 1'b1;
      cand_d.id       = idx_i;
      cand_d.deadline = deadline_q;
      cand_d.start    = start_q;
      cand_d.order    = order_q;
    end else begin
      cand_d = cand_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q    <= '0;
      deadline_q <= '0;
      order_q    <= '0;
      waiting_q  <= 1'b0;
      cand_q     <= '0;
    end else begin
      cand_q <= cand_d;
      if (wr_i.en && (wr_i.slot == idx_i)) begin
        start_q    <= wr_i.start;
        deadline_q <= wr_i.deadline;
        order_q    <= wr_i.order;
        waiting_q  <= 1'b1;
      end else if (clr_i.all || (clr_i.en && (clr_i.slot == idx_i))) begin
        waiting_q <= 1'b0;
      end
    end
  end

  assign cand_o    = cand_q;
  assign waiting_o = waiting_q;

endmodule

// ===== tb/tb_emulated_time_timeout_queue.sv =====
// Self-checking testbench for the emulated-time timeout queue.
module tb_emulated_time_timeout_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import ettq_pkg::*;

  localparam int unsigned CycleLimit = 8_000_000;
  localparam int unsigned DrainWait  = 300;
  localparam int unsigned FillAhead  = 64;
  localparam int unsigned PhaseItems = 128;

  typedef struct packed {
    req_e              req;
    logic [SlotW-1:0]  slot;
    logic [TimeW-1:0]  duration;
    logic [DeltaW-1:0] delta;
    int unsigned       idle_pct;
    bit                drain;
  } timer_req_t;

  typedef struct packed {
    ev_e              ev;
    logic [SlotW-1:0] slot;
    logic             reached;
    logic [TimeW-1:0] elapsed;
    logic             last;
  } timer_res_t;

  logic              clk_i;
  logic              rst_ni        = 1'b0;
  logic              start         = 1'b0;
  logic              busy;
  logic [1:0]        req_type_i    = '0;
  logic [3:0]        slot_i        = '0;
  logic [47:0]       duration_ns_i = '0;
  logic [31:0]       delta_ns_i    = '0;
  logic              res_strobe_o;
  logic [1:0]        event_res_o;
  logic [3:0]        out_slot_o;
  logic              reached_o;
  logic [47:0]       elapsed_o;
  logic              last_o;

  emulated_time_timeout_queue dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .req_type_i   (req_type_i),
    .slot_i       (slot_i),
    .duration_ns_i(duration_ns_i),
    .delta_ns_i   (delta_ns_i),
    .res_strobe_o (res_strobe_o),
    .event_res_o  (event_res_o),
    .out_slot_o   (out_slot_o),
    .reached_o    (reached_o),
    .elapsed_o    (elapsed_o),
    .last_o       (last_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Timer state mirrored from the accepted requests.
  logic [TimeW-1:0]  clock_ns;
  logic [TimeW-1:0]  slot_start_ns    [NumSlots];
  logic [TimeW-1:0]  slot_deadline_ns [NumSlots];
  logic              slot_waiting     [NumSlots];
  logic [OrderW-1:0] slot_seq         [NumSlots];
  logic [OrderW-1:0] start_seq;

  timer_req_t  req_q[$];
  timer_res_t  due_q[$];
  timer_req_t  drv_item;
  bit          took_beat = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned sender_idle_pct = 0;
  bit          drain_next = 1'b0;
  int unsigned queued = 0;

  initial begin
    clock_ns  = '0;
    start_seq = '0;
    for (int i = 0; i < NumSlots; i++) begin
      slot_start_ns[i]    = '0;
      slot_deadline_ns[i] = '0;
      slot_waiting[i]     = 1'b0;
      slot_seq[i]         = '0;
    end
  end

  function automatic void push_result(ev_e ev, logic [SlotW-1:0] slot, logic reached,
                                      logic [TimeW-1:0] elapsed, logic last);
    timer_res_t r;
    r.ev      = ev;
    r.slot    = slot;
    r.reached = reached;
    r.elapsed = elapsed;
    r.last    = last;
    due_q = {due_q, r};
  endfunction

  // Earliest deadline among waiting slots (expired ones only if asked), ties broken by start order.
  function automatic int next_due_slot(bit expired_only);
    int sel;
    sel = -1;
    for (int i = 0; i < NumSlots; i++) begin
      if (slot_waiting[i] && !(expired_only && slot_deadline_ns[i] > clock_ns)) begin
        if (sel < 0 || slot_deadline_ns[i] < slot_deadline_ns[sel] ||
            (slot_deadline_ns[i] == slot_deadline_ns[sel] && slot_seq[i] < slot_seq[sel]))
          sel = i;
      end
    end
    return sel;
  endfunction

  function automatic void free_slots(bit expired_only, bit free_all);
    int               n;
    int               s;
    logic [SlotW-1:0] ids [MaxRes];
    logic [TimeW-1:0] els [MaxRes];
    n = 0;
    s = next_due_slot(expired_only);
    while (n < MaxRes && s >= 0) begin
      slot_waiting[s] = 1'b0;
      ids[n] = SlotW'(s);
      els[n] = clock_ns - slot_start_ns[s];
      n++;
      s = next_due_slot(expired_only);
    end
    if (free_all)
      for (int i = 0; i < NumSlots; i++) slot_waiting[i] = 1'b0;
    if (n == 0)
      push_result(EV_NONE, '0, 1'b0, '0, 1'b1);
    for (int k = 0; k < n; k++)
      push_result(EV_RELEASED, ids[k], 1'b1, els[k], k == n - 1);
  endfunction

  function automatic void apply_request(logic [1:0] req, logic [SlotW-1:0] slot,
                                        logic [TimeW-1:0] dur, logic [DeltaW-1:0] delta);
    case (req)
      REQ_START: begin
        slot_start_ns[slot]    = clock_ns;
        slot_deadline_ns[slot] = clock_ns + dur;
        slot_waiting[slot]     = 1'b1;
        slot_seq[slot]         = start_seq;
        start_seq              = start_seq + 1'b1;
        push_result(EV_STARTED, slot, 1'b0, '0, 1'b1);
      end
      REQ_STEP: begin
        clock_ns = clock_ns + TimeW'(delta);
        free_slots(1'b1, 1'b0);
      end
      REQ_QUERY: begin
        push_result(EV_QUERY, slot, clock_ns >= slot_deadline_ns[slot],
                    clock_ns - slot_start_ns[slot], 1'b1);
      end
      default: free_slots(1'b0, 1'b1);
    endcase
  endfunction

  function automatic void check_beat();
    timer_res_t r;
    if (due_q.size() == 0) begin
      $error("unexpected result beat: event_res %0d out_slot %0d", event_res_o, out_slot_o);
      errors++;
    end else begin
      r = due_q.pop_front();
      if (event_res_o !== r.ev) begin
        $error("event_res: expected %0d, got %0d", r.ev, event_res_o);
        errors++;
      end
      if (out_slot_o !== r.slot) begin
        $error("out_slot: expected %0d, got %0d", r.slot, out_slot_o);
        errors++;
      end
      if (reached_o !== r.reached) begin
        $error("reached: expected %0d, got %0d", r.reached, reached_o);
        errors++;
      end
      if (elapsed_o !== r.elapsed) begin
        $error("elapsed: expected %0d, got %0d", r.elapsed, elapsed_o);
        errors++;
      end
      if (last_o !== r.last) begin
        $error("last: expected %0d, got %0d", r.last, last_o);
        errors++;
      end
    end
  endfunction

  // Check result beats first, then predict for a request taken at this edge.
  always @(posedge clk_i) begin
    took_beat = rst_ni && start && !busy;
    if (rst_ni && res_strobe_o) check_beat();
    if (took_beat) apply_request(req_type_i, slot_i, duration_ns_i, delta_ns_i);
  end

  // Hold the request until taken; drained requests wait for all results.
  always @(negedge clk_i) begin
    if (rst_ni && (!start || took_beat)) begin
      if (req_q.size() != 0 && !(req_q[0].drain && due_q.size() != 0) &&
          $urandom_range(0, 99) >= req_q[0].idle_pct) begin
        drv_item      = req_q.pop_front();
        start         <= 1'b1;
        req_type_i    <= drv_item.req;
        slot_i        <= drv_item.slot;
        duration_ns_i <= drv_item.duration;
        delta_ns_i    <= drv_item.delta;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_req(req_e req, logic [SlotW-1:0] slot, logic [TimeW-1:0] dur,
                           logic [DeltaW-1:0] delta);
    timer_req_t t;
    while (req_q.size() > FillAhead) @(negedge clk_i);
    t.req      = req;
    t.slot     = slot;
    t.duration = dur;
    t.delta    = delta;
    t.idle_pct = sender_idle_pct;
    t.drain    = drain_next;
    drain_next = 1'b0;
    queued++;
    req_q = {req_q, t};
  endtask

  function automatic logic [SlotW-1:0] rand_slot();
    return SlotW'($urandom_range(0, NumSlots - 1));
  endfunction

  function automatic logic [TimeW-1:0] rand_wide();
    return TimeW'({$urandom, $urandom});
  endfunction

  function automatic logic [TimeW-1:0] pick_duration();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return rand_wide();
      3:       return TimeW'($urandom);
      default: return TimeW'($urandom_range(0, 3000));
    endcase
  endfunction

  function automatic logic [DeltaW-1:0] pick_delta();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(0, 2000);
    endcase
  endfunction

  // Arm a few timers, peek at some, then advance the clock.
  task automatic timer_burst();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) begin
      queue_req(REQ_START, rand_slot(), pick_duration(), $urandom);
      if ($urandom_range(0, 3) == 0)
        queue_req(REQ_QUERY, rand_slot(), rand_wide(), $urandom);
    end
    repeat ($urandom_range(1, 4))
      queue_req(REQ_STEP, rand_slot(), rand_wide(), pick_delta());
  endtask

  // Arm every slot with a short timeout, then expire them all in one step.
  task automatic fill_and_expire();
    int base;
    base = $urandom_range(0, 15);
    for (int i = 0; i < NumSlots; i++)
      queue_req(REQ_START, SlotW'((base + i) % NumSlots), TimeW'($urandom_range(0, 64)),
                $urandom);
    queue_req(REQ_STEP, rand_slot(), rand_wide(), $urandom_range(64, 200));
    queue_req(REQ_STEP, rand_slot(), rand_wide(), pick_delta());
  endtask

  task automatic random_phase(int unsigned idle_pct, int unsigned count);
    int unsigned stop_at;
    int unsigned kind;
    sender_idle_pct = idle_pct;
    drain_next      = 1'b1;
    stop_at         = queued + count;
    while (queued < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind <= 5) begin
        timer_burst();
      end else if (kind <= 7) begin
        fill_and_expire();
      end else if (kind == 8) begin
        repeat ($urandom_range(0, 8))
          queue_req(REQ_START, rand_slot(), pick_duration(), $urandom);
        queue_req(REQ_REL_ALL, rand_slot(), rand_wide(), $urandom);
      end else begin
        repeat ($urandom_range(1, 4))
          queue_req(req_e'($urandom_range(0, 3)), rand_slot(),
                    pick_duration(), pick_delta());
      end
    end
  endtask

  initial begin
    // Directed opening: empty queue, extremes, ties, restart, deadline wrap.
    queue_req(REQ_QUERY,   4'd0,  '0, '0);
    queue_req(REQ_STEP,    4'd0,  '0, '0);
    queue_req(REQ_REL_ALL, 4'd0,  '0, '0);
    queue_req(REQ_START,   4'd15, '1, '0);
    queue_req(REQ_START,   4'd0,  '0, '0);
    queue_req(REQ_STEP,    4'd0,  '0, '0);
    queue_req(REQ_START,   4'd3,  48'd5, '0);
    queue_req(REQ_START,   4'd4,  48'd5, '0);
    queue_req(REQ_START,   4'd3,  48'd2, '0);
    queue_req(REQ_QUERY,   4'd4,  '0, '0);
    queue_req(REQ_STEP,    4'd0,  '0, '1);
    queue_req(REQ_QUERY,   4'd15, '0, '0);
    queue_req(REQ_START,   4'd9,  '0, '0);
    queue_req(REQ_START,   4'd8,  '0, '0);
    queue_req(REQ_REL_ALL, 4'd15, '1, '1);
    queue_req(REQ_START,   4'd1,  '1, '0);
    queue_req(REQ_STEP,    4'd0,  '0, '0);
    queue_req(REQ_QUERY,   4'd1,  '0, '0);
    queue_req(REQ_START,   4'd2,  48'hAAAA_AAAA_AAAA, 32'h5555_5555);
    queue_req(REQ_START,   4'd6,  48'h5555_5555_5555, 32'hAAAA_AAAA);
    queue_req(REQ_QUERY,   4'd2,  '0, '0);
    queue_req(REQ_REL_ALL, 4'd0,  '0, '0);

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    random_phase(0, PhaseItems);
    random_phase(82, PhaseItems);
    random_phase(13, PhaseItems);

    while (req_q.size() != 0 || due_q.size() != 0 || start) @(negedge clk_i);
    repeat (DrainWait) @(negedge clk_i);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== emulated_time_timeout_queue.f =====
sv/ettq_pkg.sv
sv/ettq_cell.sv
sv/emulated_time_timeout_queue.sv
tb/tb_emulated_time_timeout_queue.sv
